[src/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg: shared constants for the rational arithmetic unit
// Request codes, port widths and the default word size.
// ----------------------------------------------------------------------------
package rar_pkg;

	// Port widths fixed by the interface
	localparam int unsigned FIELD_BITS = 32;
	localparam int unsigned REQ_BITS   = 3;

	// Default internal word size (arithmetic wraps at this width)
	localparam int unsigned WORD_BITS_DEF = 32;

	// Request codes
	localparam logic [REQ_BITS-1:0] REQ_ADD     = 3'd0;
	localparam logic [REQ_BITS-1:0] REQ_SUB     = 3'd1;
	localparam logic [REQ_BITS-1:0] REQ_ADD_INT = 3'd2;
	localparam logic [REQ_BITS-1:0] REQ_SUB_INT = 3'd3;
	localparam logic [REQ_BITS-1:0] REQ_INVERSE = 3'd4;
	localparam logic [REQ_BITS-1:0] REQ_REDUCE  = 3'd5;

endpackage

[src/rational_arith_reduce_unit.sv]
// ----------------------------------------------------------------------------
// rational_arith_reduce_unit: fraction arithmetic with GCD reduction
// Iterative unit built around one shared add/subtract datapath.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid/req_ready): one item names an operation
//   (req_type) on fraction A = a_num/a_den and an operand B (b_num/b_den, or
//   the integer b_num). Result channel (res_valid/res_ready): one item per
//   request, res_num/res_den plus zero_gcd_error for reduce of 0/0.
//   Arithmetic runs at WORD_BITS bits, two's complement, wrapping; results are
//   sign-extended onto the 32-bit ports.
// Sequencing: the single shared adder carries every multiply step, divide
//   step and GCD step. Inverse, undefined codes and add/subtract with equal
//   denominators finish without a multiply; add/subtract integer multiply
//   b_num by a_den first; cross-multiplied add/subtract multiply out both
//   numerator terms and the denominator; reduce runs the binary GCD loop, one
//   shift, subtract or swap per step, then divides both parts by the GCD.
// Throughput: one item at a time; req_ready is high only while idle.
// Reset: arst_n clears the sequencer and res_valid; no clearing pass.
// Stall: a finished result waits in the output register; a new item may be
//   accepted meanwhile, and its result waits in the sequencer until the
//   output register frees.
// ----------------------------------------------------------------------------
module rational_arith_reduce_unit #(
	parameter int unsigned WORD_BITS = rar_pkg::WORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request channel
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  logic        [rar_pkg::REQ_BITS-1:0]   req_type,
	input  logic signed [rar_pkg::FIELD_BITS-1:0] a_num,
	input  logic signed [rar_pkg::FIELD_BITS-1:0] a_den,
	input  logic signed [rar_pkg::FIELD_BITS-1:0] b_num,
	input  logic signed [rar_pkg::FIELD_BITS-1:0] b_den,
	// result channel
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic signed [rar_pkg::FIELD_BITS-1:0] res_num,
	output logic signed [rar_pkg::FIELD_BITS-1:0] res_den,
	output logic                                  zero_gcd_error
);

	localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);
	localparam int unsigned K_BITS   = $clog2(WORD_BITS);

	// Sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_F1    = 4'd4;
	localparam logic [3:0] S_F2    = 4'd5;
	localparam logic [3:0] S_F3    = 4'd6;
	localparam logic [3:0] S_I1    = 4'd7;
	localparam logic [3:0] S_R1    = 4'd8;
	localparam logic [3:0] S_GSH   = 4'd9;
	localparam logic [3:0] S_GLOOP = 4'd10;
	localparam logic [3:0] S_R2    = 4'd11;
	localparam logic [3:0] S_R3    = 4'd12;
	localparam logic [3:0] S_R4    = 4'd13;
	localparam logic [3:0] S_R5    = 4'd14;
	localparam logic [3:0] S_FIN   = 4'd15;

	logic [3:0]                     state_q;
	logic [3:0]                     ret_q;     // state to resume after MUL/DIV
	logic [CNT_BITS-1:0]            cnt_q;
	logic [K_BITS-1:0]              k_q;       // common power of two in GCD
	logic [rar_pkg::REQ_BITS-1:0]   op_q;
	logic [WORD_BITS-1:0]           an_q, ad_q, bn_q, bd_q;
	logic [WORD_BITS-1:0]           x_q, y_q, acc_q, g_q;
	logic signed [WORD_BITS-1:0]    rn_q, rd_q;
	logic                           err_q;

	// Shared adder/subtractor
	logic [WORD_BITS-1:0] add_a, add_b, add_res;
	logic                 add_sub, add_c;
	logic [WORD_BITS:0]   add_sum;

	// Divide step operands
	logic [WORD_BITS-1:0] rem_sh;
	logic                 out_load;

	assign rem_sh = {acc_q[WORD_BITS-2:0], y_q[WORD_BITS-1]};

	// Route operands to the one adder according to the sequencer step
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			S_START: begin
				case (op_q)
					rar_pkg::REQ_ADD, rar_pkg::REQ_SUB: begin
						add_a   = an_q;
						add_b   = bn_q;
						add_sub = (op_q == rar_pkg::REQ_SUB);
					end
					rar_pkg::REQ_REDUCE: begin
						add_b   = an_q;
						add_sub = 1'b1;
					end
					default: begin
						add_sub = 1'b0;
					end
				endcase
			end
			S_MUL: begin
				add_a = acc_q;
				add_b = y_q[0] ? x_q : '0;
			end
			S_DIV: begin
				add_a   = rem_sh;
				add_b   = x_q;
				add_sub = 1'b1;
			end
			S_F2: begin
				add_a   = rn_q;
				add_b   = acc_q;
				add_sub = (op_q == rar_pkg::REQ_SUB);
			end
			S_I1: begin
				add_a   = an_q;
				add_b   = acc_q;
				add_sub = (op_q == rar_pkg::REQ_SUB_INT);
			end
			S_R1, S_R4: begin
				add_b   = ad_q;
				add_sub = 1'b1;
			end
			S_R2: begin
				add_b   = an_q;
				add_sub = 1'b1;
			end
			S_GLOOP: begin
				add_a   = y_q;
				add_b   = x_q;
				add_sub = 1'b1;
			end
			S_R3, S_R5: begin
				add_b   = y_q;
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
		+ {{WORD_BITS{1'b0}}, add_sub};
	assign add_res = add_sum[WORD_BITS-1:0];
	assign add_c   = add_sum[WORD_BITS];   // for subtract: 1 when no borrow

	assign req_ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_FIN) && (!res_valid || res_ready);

	// Sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						// capture the item, keeping the low word bits only
						op_q    <= req_type;
						an_q    <= a_num[WORD_BITS-1:0];
						ad_q    <= a_den[WORD_BITS-1:0];
						bn_q    <= b_num[WORD_BITS-1:0];
						bd_q    <= b_den[WORD_BITS-1:0];
						state_q <= S_START;
					end
				end
				S_START: begin
					err_q <= 1'b0;
					rn_q  <= an_q;
					rd_q  <= ad_q;
					case (op_q)
						rar_pkg::REQ_ADD, rar_pkg::REQ_SUB: begin
							if (ad_q == bd_q) begin
								rn_q    <= add_res;
								state_q <= S_FIN;
							end else begin
								x_q     <= an_q;
								y_q     <= bd_q;
								acc_q   <= '0;
								cnt_q   <= CNT_BITS'(WORD_BITS);
								ret_q   <= S_F1;
								state_q <= S_MUL;
							end
						end
						rar_pkg::REQ_ADD_INT, rar_pkg::REQ_SUB_INT: begin
							x_q     <= ad_q;
							y_q     <= bn_q;
							acc_q   <= '0;
							cnt_q   <= CNT_BITS'(WORD_BITS);
							ret_q   <= S_I1;
							state_q <= S_MUL;
						end
						rar_pkg::REQ_INVERSE: begin
							rn_q    <= ad_q;
							rd_q    <= an_q;
							state_q <= S_FIN;
						end
						rar_pkg::REQ_REDUCE: begin
							if (an_q == '0 && ad_q == '0) begin
								err_q   <= 1'b1;
								state_q <= S_FIN;
							end else begin
								x_q     <= an_q[WORD_BITS-1] ? add_res : an_q;
								state_q <= S_R1;
							end
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_MUL: begin
					// shift-add, low word of the product only
					acc_q <= add_res;
					x_q   <= x_q << 1;
					y_q   <= y_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1)) begin
						state_q <= ret_q;
					end
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (add_c) begin
						acc_q <= add_res;
					end else begin
						acc_q <= rem_sh;
					end
					y_q   <= {y_q[WORD_BITS-2:0], add_c};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1)) begin
						state_q <= ret_q;
					end
				end
				S_F1: begin
					rn_q    <= acc_q;
					x_q     <= bn_q;
					y_q     <= ad_q;
					acc_q   <= '0;
					cnt_q   <= CNT_BITS'(WORD_BITS);
					ret_q   <= S_F2;
					state_q <= S_MUL;
				end
				S_F2: begin
					rn_q    <= add_res;
					x_q     <= ad_q;
					y_q     <= bd_q;
					acc_q   <= '0;
					cnt_q   <= CNT_BITS'(WORD_BITS);
					ret_q   <= S_F3;
					state_q <= S_MUL;
				end
				S_F3: begin
					rd_q    <= acc_q;
					state_q <= S_FIN;
				end
				S_I1: begin
					rn_q    <= add_res;
					state_q <= S_FIN;
				end
				S_R1: begin
					y_q     <= ad_q[WORD_BITS-1] ? add_res : ad_q;
					k_q     <= '0;
					state_q <= S_GSH;
				end
				S_GSH: begin
					// strip the common power of two; move a lone zero into y
					if (x_q == '0) begin
						x_q     <= y_q;
						y_q     <= '0;
						state_q <= S_GLOOP;
					end else if (y_q == '0) begin
						state_q <= S_GLOOP;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_GLOOP;
					end
				end
				S_GLOOP: begin
					if (y_q == '0) begin
						g_q     <= x_q << k_q;
						state_q <= S_R2;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (add_c) begin
						y_q <= add_res;
					end else begin
						// swap so that the subtract never borrows
						x_q <= y_q;
						y_q <= x_q;
					end
				end
				S_R2: begin
					x_q     <= g_q;
					y_q     <= an_q[WORD_BITS-1] ? add_res : an_q;
					acc_q   <= '0;
					cnt_q   <= CNT_BITS'(WORD_BITS);
					ret_q   <= S_R3;
					state_q <= S_DIV;
				end
				S_R3: begin
					rn_q    <= an_q[WORD_BITS-1] ? add_res : y_q;
					state_q <= S_R4;
				end
				S_R4: begin
					x_q     <= g_q;
					y_q     <= ad_q[WORD_BITS-1] ? add_res : ad_q;
					acc_q   <= '0;
					cnt_q   <= CNT_BITS'(WORD_BITS);
					ret_q   <= S_R5;
					state_q <= S_DIV;
				end
				S_R5: begin
					rd_q    <= ad_q[WORD_BITS-1] ? add_res : y_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_num        <= rar_pkg::FIELD_BITS'(rn_q);
			res_den        <= rar_pkg::FIELD_BITS'(rd_q);
			zero_gcd_error <= err_q;
		end
	end

	// Checks
	a_loop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_DIV) |-> cnt_q != '0)
		else $error("iteration counter ran out inside a loop");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> x_q != '0)
		else $error("divide started with a zero divisor");

	a_gcd_x_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GLOOP |-> x_q != '0)
		else $error("GCD loop lost its nonzero operand");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && zero_gcd_error) |-> (res_num == '0 && res_den == '0))
		else $error("zero GCD error with a nonzero result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("accepted item did not start the sequencer");

endmodule
